[sv/sbs_pkg.sv]
`timescale 1ns / 1ps

package sbs_pkg;

  // Set geometry. BLOCK_BITS must be a power of two.
  localparam int BLOCK_BITS  = 64;
  localparam int NUM_BLOCKS  = 64;
  localparam int STORE_DEPTH = 16;

  // Fixed field widths.
  localparam int FUNC_W    = 2;
  localparam int ELEM_W    = 12;
  localparam int CNT_W     = 13;
  localparam int OUT_BLK_W = 5;

  // Derived widths.
  localparam int BIT_W  = $clog2(BLOCK_BITS);
  localparam int TAG_W  = ELEM_W - BIT_W;
  localparam int USED_W = $clog2(STORE_DEPTH + 1);

  // Operation codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    F_INSERT = 2'd0,
    F_REMOVE = 2'd1,
    F_TOGGLE = 2'd2,
    F_TEST   = 2'd3
  } func_t;

  // Result status codes.
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // Control states of the top level.
  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

  // Command broadcast to every cell of the store chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SET,
    CELL_CLEAR,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [TAG_W-1:0] tag;
    logic [BIT_W-1:0] bit_idx;
  } cell_cmd_t;

  // Contents of one cell: block number and its bitmap word.
  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic [BLOCK_BITS-1:0] word;
  } cell_data_t;

  // Per-cell lookup flags against the current key.
  typedef struct packed {
    logic lt;
    logic hit;
    logic bit_on;
    logic empties;
  } cell_flags_t;

endpackage

[sv/sbs_in_if.sv]
`timescale 1ns / 1ps

interface sbs_in_if;
  logic                      valid;
  logic                      ready;
  logic [sbs_pkg::FUNC_W-1:0] func;
  logic [sbs_pkg::ELEM_W-1:0] element;

  modport source (output valid, output func, output element, input ready);
  modport sink   (input valid, input func, input element, output ready);
endinterface

[sv/sbs_out_if.sv]
`timescale 1ns / 1ps

interface sbs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         was_member;
  logic                         is_member;
  logic [sbs_pkg::CNT_W-1:0]     cardinality;
  logic [sbs_pkg::OUT_BLK_W-1:0] blocks_in_use;
  logic                         status;

  modport source (output valid, output was_member, output is_member, output cardinality,
                  output blocks_in_use, output status, input ready);
  modport sink   (input valid, input was_member, input is_member, input cardinality,
                  input blocks_in_use, input status, output ready);
endinterface

[sv/sparse_bitset_element_ops.sv]
`timescale 1ns / 1ps

// Channel | Dir | Words                                   | Handshake
// in_ch   | in  | func, element                           | valid/ready
// out_ch  | out | was_member, is_member, cardinality,     | valid/ready
//         |     | blocks_in_use, status                   |
//
// Each item is accepted in the idle state and then handled in the update
// state, in which the cell chain compares, reduces and shifts in place.
// The update cycle waits while the output register still holds an untaken
// word; the input is ready again right after the update.
// Reset (rst_n low, synchronous) empties the set; store cells need no clear,
// since only cells below the block count are ever looked at.
module sparse_bitset_element_ops (
  input  logic       clk,
  input  logic       rst_n,
  sbs_in_if.sink     in_ch,
  sbs_out_if.source  out_ch
);

  localparam int D = sbs_pkg::STORE_DEPTH;

  sbs_pkg::state_t                state_r, state_nxt;
  logic [sbs_pkg::FUNC_W-1:0]     func_r;
  logic [sbs_pkg::ELEM_W-1:0]     elem_r;
  logic [sbs_pkg::USED_W-1:0]     used_r, used_nxt;
  logic [sbs_pkg::CNT_W-1:0]      count_r, count_nxt;

  logic                           out_valid_r;
  logic                           was_r, now_r, status_r;
  logic [sbs_pkg::CNT_W-1:0]      card_r;
  logic [sbs_pkg::OUT_BLK_W-1:0]  blk_used_r;

  logic [sbs_pkg::TAG_W-1:0]      blk;
  logic [sbs_pkg::BIT_W-1:0]      bit_idx;
  logic                           in_range;
  logic                           upd_go;
  logic                           present, was, last_bit, full;
  logic                           now, status;
  sbs_pkg::cell_op_t              op;
  sbs_pkg::cell_cmd_t             cmd;

  sbs_pkg::cell_data_t            data_v  [D];
  sbs_pkg::cell_flags_t           flags_v [D];
  logic [D-1:0]                   hit_v, on_v, empty_v;

  assign blk      = elem_r[sbs_pkg::ELEM_W-1:sbs_pkg::BIT_W];
  assign bit_idx  = elem_r[sbs_pkg::BIT_W-1:0];
  assign in_range = (int'(blk) < sbs_pkg::NUM_BLOCKS);
  assign upd_go   = (state_r == sbs_pkg::ST_UPD) && (!out_valid_r || out_ch.ready);
  assign full     = (used_r >= sbs_pkg::USED_W'(D));

  // Store chain, one cell per slot in rank order.
  for (genvar i = 0; i < D; i++) begin : g_cell
    sbs_pkg::cell_data_t below, above;
    logic                lt_below;
    logic                valid;

    if (i == 0) begin : g_first
      assign below    = data_v[i];
      assign lt_below = 1'b1;
    end else begin : g_mid
      assign below    = data_v[i-1];
      assign lt_below = flags_v[i-1].lt;
    end
    if (i == D - 1) begin : g_last
      assign above = data_v[i];
    end else begin : g_up
      assign above = data_v[i+1];
    end

    assign valid = (sbs_pkg::USED_W'(i) < used_r);

    sbs_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (valid),
      .lt_below   (lt_below),
      .data_below (below),
      .data_above (above),
      .data       (data_v[i]),
      .flags      (flags_v[i])
    );

    assign hit_v[i]   = flags_v[i].hit;
    assign on_v[i]    = flags_v[i].bit_on;
    assign empty_v[i] = flags_v[i].empties;
  end

  // Reduce the cell flags: the key's block can match at most one cell.
  assign present  = |hit_v;
  assign was      = |(hit_v & on_v);
  assign last_bit = |(hit_v & empty_v);

  // Decide the operation on the chain and the counter updates.
  always_comb begin
    op        = sbs_pkg::CELL_HOLD;
    now       = was;
    status    = sbs_pkg::STAT_DONE;
    used_nxt  = used_r;
    count_nxt = count_r;
    if (in_range) begin
      if ((sbs_pkg::func_t'(func_r) == sbs_pkg::F_INSERT ||
           (sbs_pkg::func_t'(func_r) == sbs_pkg::F_TOGGLE && !was)) && !was) begin
        if (present) begin
          op        = sbs_pkg::CELL_SET;
          now       = 1'b1;
          count_nxt = count_r + 1'b1;
        end else if (!full) begin
          op        = sbs_pkg::CELL_INSERT;
          now       = 1'b1;
          count_nxt = count_r + 1'b1;
          used_nxt  = used_r + 1'b1;
        end else begin
          status = sbs_pkg::STAT_FULL;
        end
      end else if ((sbs_pkg::func_t'(func_r) == sbs_pkg::F_REMOVE ||
                    sbs_pkg::func_t'(func_r) == sbs_pkg::F_TOGGLE) && was) begin
        now       = 1'b0;
        count_nxt = count_r - 1'b1;
        if (last_bit) begin
          op       = sbs_pkg::CELL_REMOVE;
          used_nxt = used_r - 1'b1;
        end else begin
          op = sbs_pkg::CELL_CLEAR;
        end
      end
    end
  end

  // The chain only moves on the edge that also loads the result.
  always_comb begin
    cmd.op      = upd_go ? op : sbs_pkg::CELL_HOLD;
    cmd.tag     = blk;
    cmd.bit_idx = bit_idx;
  end

  // Control state machine.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbs_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = sbs_pkg::ST_UPD;
      end
      sbs_pkg::ST_UPD: begin
        if (upd_go) state_nxt = sbs_pkg::ST_IDLE;
      end
      default: state_nxt = sbs_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == sbs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbs_pkg::ST_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        used_r      <= used_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input capture and result word.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      elem_r <= in_ch.element;
    end
    if (upd_go) begin
      was_r      <= was;
      now_r      <= now;
      status_r   <= status;
      card_r     <= count_nxt;
      blk_used_r <= sbs_pkg::OUT_BLK_W'(used_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.was_member    = was_r;
  assign out_ch.is_member     = now_r;
  assign out_ch.cardinality   = card_r;
  assign out_ch.blocks_in_use = blk_used_r;
  assign out_ch.status        = status_r;

endmodule

[sv/sbs_cell.sv]
`timescale 1ns / 1ps

// One slot of the packed block store. Cells are chained in rank order and
// each sees the contents of its neighbors below and above, so an insert
// shifts the chain up and a block removal shifts it down.
module sbs_cell (
  input  logic                clk,
  input  sbs_pkg::cell_cmd_t  cmd,
  input  logic                valid,
  input  logic                lt_below,
  input  sbs_pkg::cell_data_t data_below,
  input  sbs_pkg::cell_data_t data_above,
  output sbs_pkg::cell_data_t data,
  output sbs_pkg::cell_flags_t flags
);

  sbs_pkg::cell_data_t           data_r;
  sbs_pkg::cell_data_t           data_nxt;
  logic [sbs_pkg::BLOCK_BITS-1:0] onehot;

  assign onehot = sbs_pkg::BLOCK_BITS'(1) << cmd.bit_idx;
  assign data   = data_r;

  // Compare the held block against the key.
  always_comb begin
    flags.lt      = valid && (data_r.tag < cmd.tag);
    flags.hit     = valid && (data_r.tag == cmd.tag);
    flags.bit_on  = data_r.word[cmd.bit_idx];
    flags.empties = ((data_r.word & ~onehot) == '0);
  end

  // Next contents. Cells at or above the rank move on insert and removal;
  // the cell at the rank itself takes the new word on insert.
  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      sbs_pkg::CELL_SET: begin
        if (flags.hit) data_nxt.word = data_r.word | onehot;
      end
      sbs_pkg::CELL_CLEAR: begin
        if (flags.hit) data_nxt.word = data_r.word & ~onehot;
      end
      sbs_pkg::CELL_INSERT: begin
        if (!flags.lt) begin
          if (lt_below) begin
            data_nxt.tag  = cmd.tag;
            data_nxt.word = onehot;
          end else begin
            data_nxt = data_below;
          end
        end
      end
      sbs_pkg::CELL_REMOVE: begin
        if (!flags.lt) data_nxt = data_above;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

[sv/sbs_checker.sv]
`timescale 1ns / 1ps

module sbs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_was_member,
  input logic                          out_is_member,
  input logic [sbs_pkg::CNT_W-1:0]     out_cardinality,
  input logic [sbs_pkg::OUT_BLK_W-1:0] out_blocks_in_use,
  input logic                          out_status
);

  // Only one item is in flight: an accepted word blocks the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is still in flight");

  // A stalled result word holds its count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cardinality))
    else $error("stalled result word changed");

  // A refused insert leaves the element out of the set.
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_was_member && !out_is_member)
    else $error("refused insert reports membership");

  // A member implies a non-empty set and at least one stored block.
  a_member_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_member |-> out_cardinality != '0 && out_blocks_in_use != '0)
    else $error("member reported in an empty set");

  // The block count never exceeds the store depth.
  a_blocks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_blocks_in_use) <= sbs_pkg::STORE_DEPTH)
    else $error("block count beyond store depth");

endmodule

bind sparse_bitset_element_ops sbs_checker u_sbs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_was_member    (out_ch.was_member),
  .out_is_member     (out_ch.is_member),
  .out_cardinality   (out_ch.cardinality),
  .out_blocks_in_use (out_ch.blocks_in_use),
  .out_status        (out_ch.status)
);
